>>> rtl/bss_pkg.sv
package bss_pkg;

    // Field widths
    localparam int EastW   = 40;
    localparam int DistW   = 32;
    localparam int BearW   = 25;
    localparam int IntW    = 16;
    localparam int IdxW    = 6;
    localparam int CntW    = 7;
    localparam int InDataW = 144;
    localparam int OutDataW = 96;
    localparam int MulAW   = 35;
    localparam int MulBW   = 32;
    localparam int MulPW   = MulAW + MulBW;

    // Defaults for the top-level parameters
    localparam int MaxStationsDefault = 64;
    localparam int CordicStepsDefault = 32;

    localparam logic [IntW-1:0] IntervalReset = 16'd10;

    // Angle constants, degrees times 65536 and Q61 radians
    localparam logic [BearW-1:0] Deg90  = 25'd5898240;
    localparam logic [BearW-1:0] Deg180 = 25'd11796480;
    localparam logic [BearW-1:0] Deg270 = 25'd17694720;
    localparam logic [BearW-1:0] Deg360 = 25'd23592960;
    localparam logic [63:0] PiQ61        = 64'h6487ED5110B4611A;
    localparam logic [63:0] QuarterPiQ61 = 64'h1921FB54442D1846;
    localparam logic [63:0] GainQ61      = 64'd1400229935014726477;
    localparam logic [63:0] DegToRad     = PiQ61 / 64'd180;

    // atan(2^-i) in Q61 from its power series, pi/4 for i = 0
    function automatic logic [63:0] atan_q61(input int i);
        logic [63:0] sum;
        logic [63:0] t;
        int e;
        sum = 64'd0;
        if (i == 0) begin
            sum = QuarterPiQ61;
        end else begin
            for (int k = 0; k < 64; k++) begin
                e = i * (2 * k + 1);
                if (e <= 61) begin
                    t = (64'd1 << (61 - e)) / 64'(2 * k + 1);
                    if (k % 2 == 1) sum = sum - t;
                    else sum = sum + t;
                end
            end
        end
        return sum;
    endfunction

    // Controller states
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MULH  = 10'b0000000010,
        ST_MULL  = 10'b0000000100,
        ST_ZINIT = 10'b0000001000,
        ST_CORD  = 10'b0000010000,
        ST_DIV   = 10'b0000100000,
        ST_SCE   = 10'b0001000000,
        ST_SCN   = 10'b0010000000,
        ST_FIN   = 10'b0100000000,
        ST_EMIT  = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic            load;
        logic            mul_hi;
        logic            mul_lo;
        logic            z_init;
        logic            cordic;
        logic            div;
        logic            scale_e;
        logic            scale_n;
        logic            finish;
        logic            emit;
        logic [IdxW-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_now;
    } status_t;

endpackage

>>> rtl/bearing_station_stepper_unit.sv
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_tvalid / s_tready  | s_tdata: line start, distance, bearing
// m_       | out       | m_tvalid / m_tready  | m_tdata, m_tuser, m_tlast: one station
// cfg_     | in        | cfg_valid / cfg_ready| cfg_data: interval_size
//
// A line runs through load, two multiply steps (MULH, MULL), ZINIT, the CORDIC loop,
// the bit-serial divider, two scale steps (SCE, SCN) and FIN; then the output
// register takes one station per cycle when not stalled; n = 1..MAX_STATIONS stations.
// Reset (aresetn low, synchronous) returns to idle, drops m_tvalid, interval 10.
// m_tready low stalls emission; a new line is taken once the last station is in
// the output register.
module bearing_station_stepper_unit
    import bss_pkg::*;
#(
    parameter int MAX_STATIONS = MaxStationsDefault,
    parameter int CORDIC_STEPS = CordicStepsDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // start_easting[39:0], start_northing[79:40], line_distance[111:80],
    // bearing[136:112], zero pad
    input  logic [InDataW-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // station_easting[39:0], station_northing[79:40], station_index[85:80],
    // station_count[92:86], zero pad
    output logic [OutDataW-1:0] m_tdata,
    // count_saturated[0]
    output logic                m_tuser,
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IntW-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    bss_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bss_dp #(
        .MAX_STATIONS (MAX_STATIONS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

>>> rtl/bss_ctrl.sv
module bss_ctrl
    import bss_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t          state_reg, state_next;
    logic [IdxW-1:0] cnt_reg, cnt_next;

    localparam logic [IdxW-1:0] CordLast = IdxW'(CORDIC_STEPS - 1);
    localparam logic [IdxW-1:0] DivLast  = IdxW'(DistW - 1);

    assign s_tready = (state_reg == ST_IDLE);

    // Sequence one line through the datapath
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MULH;
                end
            end
            ST_MULH: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MULL;
            end
            ST_MULL: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_ZINIT;
            end
            ST_ZINIT: begin
                cmd.z_init = 1'b1;
                cnt_next   = '0;
                state_next = ST_CORD;
            end
            ST_CORD: begin
                cmd.cordic = 1'b1;
                if (cnt_reg == CordLast) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (cnt_reg == DivLast) begin
                    cnt_next   = '0;
                    state_next = ST_SCE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCE: begin
                cmd.scale_e = 1'b1;
                state_next  = ST_SCN;
            end
            ST_SCN: begin
                cmd.scale_n = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                cnt_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (st.last_now) state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/bss_dp.sv
module bss_dp
    import bss_pkg::*;
#(
    parameter int MAX_STATIONS = MaxStationsDefault,
    parameter int CORDIC_STEPS = CordicStepsDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                cfg_valid,
    input  logic [IntW-1:0]     cfg_data,
    output logic [OutDataW-1:0] m_tdata,
    output logic                m_tuser,
    output logic                m_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  cmd_t                cmd,
    output status_t             st
);

    localparam int AtW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_STATIONS);

    // Arctangent table
    logic [63:0] atan_tab [CORDIC_STEPS];
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
        assign atan_tab[g] = atan_q61(g);
    end

    logic [IntW-1:0]  interval_reg;
    logic [EastW-1:0] run_e_reg, run_n_reg, step_e_reg, step_n_reg;
    logic [1:0]       quad_reg;
    logic [22:0]      r_reg;
    logic [63:0]      x_reg, y_reg, z_reg, zhi_reg;
    logic [MulPW-1:0] prod_reg;
    logic [DistW-1:0] dvd_reg;
    logic [25:0]      rem_reg;
    logic             neg_reg;
    logic [CntW-1:0]  count_reg;
    logic             sat_reg;
    logic [EastW-1:0] out_e_reg, out_n_reg;
    logic [IdxW-1:0]  out_idx_reg;
    logic [CntW-1:0]  out_cnt_reg;
    logic             out_sat_reg, out_last_reg, out_valid_reg;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) interval_reg <= IntervalReset;
        else if (cfg_valid) interval_reg <= cfg_data;
    end

    // Bearing reduction and quadrant split
    logic [BearW-1:0] b_in, b_red, r_full;
    logic [1:0]       quad_in;
    always_comb begin
        b_in  = s_tdata[136:112];
        b_red = (b_in >= Deg360) ? b_in - Deg360 : b_in;
        if (b_red < Deg90) begin
            quad_in = 2'd0; r_full = b_red;
        end else if (b_red < Deg180) begin
            quad_in = 2'd1; r_full = b_red - Deg90;
        end else if (b_red < Deg270) begin
            quad_in = 2'd2; r_full = b_red - Deg180;
        end else begin
            quad_in = 2'd3; r_full = b_red - Deg270;
        end
    end

    // Quadrant mapping of sin and cos
    logic [63:0] s_v, c_v, v_sel, mag;
    always_comb begin
        case (quad_reg)
            2'd0: begin s_v = y_reg;         c_v = x_reg;         end
            2'd1: begin s_v = x_reg;         c_v = 64'd0 - y_reg; end
            2'd2: begin s_v = 64'd0 - y_reg; c_v = 64'd0 - x_reg; end
            default: begin s_v = 64'd0 - x_reg; c_v = y_reg; end
        endcase
        v_sel = cmd.scale_e ? s_v : c_v;
        mag   = v_sel[63] ? 64'd0 - v_sel : v_sel;
    end

    // Shared multiplier operands
    logic [MulAW-1:0] mul_a;
    logic [MulBW-1:0] mul_b;
    always_comb begin
        if (cmd.scale_e || cmd.scale_n) begin
            mul_a = mag[63:29];
            mul_b = {{(MulBW-IntW){1'b0}}, interval_reg};
        end else begin
            mul_a = {{(MulAW-23){1'b0}}, r_reg};
            mul_b = cmd.mul_hi ? DegToRad[63:32] : DegToRad[31:0];
        end
    end

    // Round the scaled product and restore its sign
    logic [63:0]      rnd;
    logic [EastW-1:0] step_val;
    always_comb begin
        rnd      = (prod_reg[63:0] + 64'd2097152) >> 22;
        step_val = neg_reg ? EastW'(64'd0 - rnd) : rnd[EastW-1:0];
    end

    // CORDIC rotation step
    logic [63:0] xs, ys, at;
    always_comb begin
        xs = $unsigned($signed(x_reg) >>> cmd.idx);
        ys = $unsigned($signed(y_reg) >>> cmd.idx);
        at = atan_tab[cmd.idx[AtW-1:0]];
    end

    // Restoring divider step
    logic [26:0] rem_sh;
    logic [25:0] divisor;
    logic        q_bit;
    always_comb begin
        divisor = {interval_reg, 10'd0};
        rem_sh  = {rem_reg, dvd_reg[DistW-1]};
        q_bit   = (rem_sh >= {1'b0, divisor});
    end

    // Station count after saturation
    logic [CntW-1:0] n_st;
    always_comb begin
        n_st        = (count_reg == '0) ? CntW'(1) : count_reg;
        st.last_now = ({1'b0, cmd.idx} + 1'b1) == n_st;
        st.out_free = !out_valid_reg || m_tready;
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            run_e_reg <= s_tdata[39:0];
            run_n_reg <= s_tdata[79:40];
            dvd_reg   <= s_tdata[111:80];
            rem_reg   <= '0;
            quad_reg  <= quad_in;
            r_reg     <= r_full[22:0];
        end
        if (cmd.mul_hi || cmd.mul_lo || cmd.scale_e || cmd.scale_n) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.mul_lo) zhi_reg <= {prod_reg[47:0], 16'd0};
        if (cmd.z_init) begin
            z_reg <= zhi_reg + {16'd0, prod_reg[63:16]};
            x_reg <= GainQ61;
            y_reg <= 64'd0;
        end
        if (cmd.cordic) begin
            if (!z_reg[63]) begin
                x_reg <= x_reg - ys; y_reg <= y_reg + xs; z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys; y_reg <= y_reg - xs; z_reg <= z_reg + at;
            end
        end
        if (cmd.div) begin
            rem_reg <= q_bit ? 26'(rem_sh - {1'b0, divisor}) : rem_sh[25:0];
            dvd_reg <= {dvd_reg[DistW-2:0], q_bit};
        end
        if (cmd.scale_e || cmd.scale_n) neg_reg <= v_sel[63];
        if (cmd.scale_n) step_e_reg <= step_val;
        if (cmd.finish) begin
            step_n_reg <= step_val;
            if (dvd_reg > DistW'(MAX_STATIONS)) begin
                count_reg <= MaxCnt;
                sat_reg   <= 1'b1;
            end else begin
                count_reg <= dvd_reg[CntW-1:0];
                sat_reg   <= 1'b0;
            end
        end
        if (cmd.emit) begin
            out_e_reg    <= run_e_reg;
            out_n_reg    <= run_n_reg;
            out_idx_reg  <= cmd.idx;
            out_cnt_reg  <= count_reg;
            out_sat_reg  <= sat_reg;
            out_last_reg <= st.last_now;
            run_e_reg    <= run_e_reg + step_e_reg;
            run_n_reg    <= run_n_reg + step_n_reg;
        end
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (cmd.emit) out_valid_reg <= 1'b1;
        else if (m_tready) out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_cnt_reg, out_idx_reg, out_n_reg, out_e_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/bss_checker.sv
module bss_checker
    import bss_pkg::*;
#(
    parameter int MAX_STATIONS = MaxStationsDefault
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    // Busy right after taking a line
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("line accepted while busy");

    // Stalled station holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled station changed");

    // Index stays below the station count
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[85:80] < m_tdata[92:86]) ||
                     (m_tdata[92:86] == 7'd0 && m_tdata[85:80] == 6'd0 && m_tlast))
        else $error("station index out of range");

    // Saturation reports the limit
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[92:86] == CntW'(MAX_STATIONS))
        else $error("saturated count wrong");

endmodule

bind bearing_station_stepper_unit bss_checker #(.MAX_STATIONS(MAX_STATIONS)) u_bss_chk (.*);

>>> verif/bearing_station_stepper_unit_tb.sv
module bearing_station_stepper_unit_tb;
    import bss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Stations = 64;
    localparam int Steps    = 32;

    // One expected station as it leaves the block
    typedef struct {
        logic [39:0] east;
        logic [39:0] north;
        logic [5:0]  idx;
        logic [6:0]  cnt;
        logic        sat;
        logic        last;
    } station_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IntW-1:0]     cfg_data;

    station_t    pending_stations[$];
    logic [15:0] spacing;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;

    bearing_station_stepper_unit #(
        .MAX_STATIONS(Stations),
        .CORDIC_STEPS(Steps)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // atan(2^-i) in Q61, power series except for the first term
    function automatic logic [63:0] arctan_term(input int i);
        logic [63:0] acc;
        int e;
        acc = 64'd0;
        if (i == 0) return 64'h1921FB54442D1846;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > 61) break;
            if (k % 2 == 1) acc = acc - ((64'd1 << (61 - e)) / 64'(2 * k + 1));
            else acc = acc + ((64'd1 << (61 - e)) / 64'(2 * k + 1));
        end
        return acc;
    endfunction

    // Scale a Q61 unit component to a Q10 step of the given spacing
    function automatic logic [39:0] step_from_unit(input logic [63:0] v,
                                                   input logic [15:0] sp);
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] rounded;
        mag = v[63] ? (64'd0 - v) : v;
        prod = (mag >> 29) * 64'(sp);
        rounded = (prod + (64'd1 << 21)) >> 22;
        return v[63] ? 40'(64'd0 - rounded) : rounded[39:0];
    endfunction

    // Lay out the stations of one accepted line
    task automatic queue_line_stations(input logic [39:0] e0, input logic [39:0] n0,
                                       input logic [31:0] line_dist, input logic [24:0] brg);
        logic [63:0] b, quad, rem, c, z, x, y, xs, ys, a, s_v, c_v, cnt, n;
        logic [39:0] de, dn, re, rn;
        logic        sat;
        station_t    st;
        b = 64'(brg);
        if (b >= 64'd23592960) b = b - 64'd23592960;
        quad = b / 64'd5898240;
        rem = b - quad * 64'd5898240;
        c = 64'h6487ED5110B4611A / 64'd180;
        z = ((rem * (c >> 32)) << 16) + ((rem * (c & 64'hFFFFFFFF)) >> 16);
        x = 64'd1400229935014726477;
        y = 64'd0;
        for (int i = 0; i < Steps; i++) begin
            xs = $signed(x) >>> i;
            ys = $signed(y) >>> i;
            a = arctan_term(i);
            if (!z[63]) begin
                x = x - ys; y = y + xs; z = z - a;
            end else begin
                x = x + ys; y = y - xs; z = z + a;
            end
        end
        case (quad)
            64'd0: begin s_v = y; c_v = x; end
            64'd1: begin s_v = x; c_v = 64'd0 - y; end
            64'd2: begin s_v = 64'd0 - y; c_v = 64'd0 - x; end
            default: begin s_v = 64'd0 - x; c_v = y; end
        endcase
        de = step_from_unit(s_v, spacing);
        dn = step_from_unit(c_v, spacing);
        sat = 1'b0;
        if (spacing == 16'd0) begin
            cnt = Stations;
            sat = 1'b1;
        end else begin
            cnt = 64'(line_dist) / (64'(spacing) << 10);
            if (cnt > Stations) begin
                cnt = Stations;
                sat = 1'b1;
            end
        end
        n = (cnt == 0) ? 64'd1 : cnt;
        re = e0;
        rn = n0;
        for (int k = 0; k < n; k++) begin
            if (k != 0) begin
                re = re + de;
                rn = rn + dn;
            end
            st.east = re;
            st.north = rn;
            st.idx = 6'(k);
            st.cnt = 7'(cnt);
            st.sat = sat;
            st.last = (k + 1 == n);
            pending_stations.push_back(st);
        end
    endtask

    // Offer one line, hold it until accepted; called at a falling edge
    task automatic send_line(input logic [39:0] e0, input logic [39:0] n0,
                             input logic [31:0] line_dist, input logic [24:0] brg);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tdata = {7'd0, brg, line_dist, n0, e0};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        queue_line_stations(e0, n0, line_dist, brg);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Write the spacing once every expected station has drained
    task automatic set_spacing(input logic [15:0] value);
        while (pending_stations.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        spacing = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drive the receiver's stall pattern
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted station with the oldest expectation
    always @(posedge aclk) begin
        station_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_stations.size() == 0) begin
                $display("%0t unexpected station: tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                error_count++;
            end else begin
                want = pending_stations.pop_front();
                if (m_tdata[39:0] !== want.east) begin
                    $display("%0t easting: expected %h actual %h",
                             $time, want.east, m_tdata[39:0]);
                    error_count++;
                end
                if (m_tdata[79:40] !== want.north) begin
                    $display("%0t northing: expected %h actual %h",
                             $time, want.north, m_tdata[79:40]);
                    error_count++;
                end
                if (m_tdata[85:80] !== want.idx) begin
                    $display("%0t index: expected %0d actual %0d",
                             $time, want.idx, m_tdata[85:80]);
                    error_count++;
                end
                if (m_tdata[92:86] !== want.cnt) begin
                    $display("%0t count: expected %0d actual %0d",
                             $time, want.cnt, m_tdata[92:86]);
                    error_count++;
                end
                if (m_tdata[95:93] !== 3'd0) begin
                    $display("%0t pad: expected 0 actual %h", $time, m_tdata[95:93]);
                    error_count++;
                end
                if (m_tuser !== want.sat) begin
                    $display("%0t saturated: expected %b actual %b",
                             $time, want.sat, m_tuser);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t last: expected %b actual %b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [39:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Edges of every field, the four quadrant boundaries, short and long lines
    task automatic test_directed();
        send_line(40'd0, 40'd0, 32'd0, 25'd0);
        send_line(40'h7FFFFFFFFF, 40'h8000000000, 32'hFFFFFFFF, 25'd5898240);
        send_line(40'h8000000000, 40'h7FFFFFFFFF, 32'd10239, 25'd11796480);
        send_line(40'hFFFFFFFFFF, 40'd1, 32'd10240, 25'd17694720);
        send_line(40'd12345, 40'hFFFFFFFFFF, 32'd655360, 25'd23592959);
        send_line(40'h7FFFFFF000, 40'h7FFFFFF000, 32'd665600, 25'd2949120);
        send_line(40'd0, 40'd0, 32'd655359, 25'd1);
        send_line(40'h8000000010, 40'h8000000010, 32'd665599, 25'd14745600);
        set_spacing(16'd1);
        send_line(40'd0, 40'd0, 32'd1023, 25'd8847360);
        send_line(rand40(), rand40(), 32'hFFFFFFFF, 25'd20643840);
        send_line(40'd0, 40'd0, 32'd65536, 25'd5898239);
        set_spacing(16'd65535);
        send_line(40'h8000000000, 40'h8000000000, 32'hFFFFFFFF, 25'd17694719);
        send_line(40'h7FFFFFFFFF, 40'h7FFFFFFFFF, 32'd67107840, 25'd11796479);
        send_line(40'd0, 40'd0, 32'd67107839, 25'd16777216);
    endtask

    // Random lines, mostly sized from zero to just past the saturation limit
    task automatic test_random(input int lines);
        logic [63:0] span;
        logic [31:0] line_dist;
        for (int i = 0; i < lines; i++) begin
            span = 64'(spacing) * 64'd1024;
            if ($urandom_range(9) < 8) begin
                span = span * 64'($urandom_range(0, 70)) + 64'($urandom_range(0, 1023));
                line_dist = (span > 64'hFFFFFFFF) ? 32'hFFFFFFFF : span[31:0];
            end else begin
                line_dist = $urandom;
            end
            send_line(rand40(), rand40(), line_dist, 25'($urandom_range(0, 23592959)));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        spacing = IntervalReset;
        error_count = 0;
        send_idle_pct = 11;
        recv_idle_pct = 66;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        set_spacing(16'd10);
        test_random(78);
        set_spacing(16'($urandom_range(1, 65535)));
        test_random(78);

        send_idle_pct = 66;
        recv_idle_pct = 11;
        set_spacing(16'($urandom_range(1, 200)));
        test_random(80);
        set_spacing(16'd1);
        test_random(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_spacing(16'd65535);
        test_random(40);
        set_spacing(16'($urandom_range(1, 65535)));
        test_random(50);

        while (pending_stations.size() != 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
